// ----- hw/rtl/sit_pkg.sv -----
// Package for the segment intersection test: widths, codes and request/result types.
`default_nettype none

package sit_pkg;

  localparam int COORD_BITS    = 32;
  localparam int EPS_BITS      = 16;
  localparam int DIR_BITS      = 16;
  localparam int DIR_FRAC_BITS = 15;

  // eps (zero-extended) times direction, then the shifted extension
  localparam int EPROD_BITS = EPS_BITS + 1 + DIR_BITS;
  localparam int EXT_BITS   = EPROD_BITS - DIR_FRAC_BITS;

  // extended points, coordinate differences, products and determinant
  localparam int PT_BITS   = ((COORD_BITS > EXT_BITS) ? COORD_BITS : EXT_BITS) + 1;
  localparam int DIFF_BITS = PT_BITS + 1;
  localparam int LO_BITS   = DIFF_BITS / 2;
  localparam int HI_BITS   = DIFF_BITS - LO_BITS;
  localparam int PPL_BITS  = DIFF_BITS + LO_BITS + 1;
  localparam int PPH_BITS  = DIFF_BITS + HI_BITS;
  localparam int PROD_BITS = 2 * DIFF_BITS;
  localparam int DET_BITS  = PROD_BITS + 1;

  localparam int N_ORIENT = 4;

  // orientation codes
  localparam logic [1:0] ORI_COLL = 2'd0;
  localparam logic [1:0] ORI_POS  = 2'd1;
  localparam logic [1:0] ORI_NEG  = 2'd2;

  // hit kinds
  localparam logic [1:0] HIT_NONE   = 2'd0;
  localparam logic [1:0] HIT_PROPER = 2'd1;
  localparam logic [1:0] HIT_COLL   = 2'd2;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] a_start_x;
    logic signed [COORD_BITS-1:0] a_start_y;
    logic signed [COORD_BITS-1:0] a_end_x;
    logic signed [COORD_BITS-1:0] a_end_y;
    logic signed [COORD_BITS-1:0] c_start_x;
    logic signed [COORD_BITS-1:0] c_start_y;
    logic signed [COORD_BITS-1:0] c_end_x;
    logic signed [COORD_BITS-1:0] c_end_y;
    logic signed [DIR_BITS-1:0]   c_dir_x;
    logic signed [DIR_BITS-1:0]   c_dir_y;
  } sit_req_t;

  typedef struct packed {
    logic       intersects;
    logic [1:0] hit_kind;
  } sit_res_t;

  typedef struct packed {
    logic signed [PT_BITS-1:0] x;
    logic signed [PT_BITS-1:0] y;
  } sit_pt_t;

endpackage

`default_nettype wire

// ----- hw/rtl/segment_intersection_test_top.sv -----
// Top level of the segment intersection test: a seven-stage pipeline.
//
// Usage
//   Request channel: drive in_req and raise start for one cycle per request.
//   busy is always low, so a request is taken at every edge with start high;
//   a new request may follow in every cycle.
//   Result channel: out_res is valid for exactly one cycle while out_strobe
//   is high. The receiver cannot stall; results leave in request order.
//   Configuration: cfg_we with cfg_wdata writes extend_epsilon (reset 1).
//   Write it only while no request is in flight.
// Timing
//   Throughput is one request per cycle. out_strobe rises as the request
//   leaves the last stage. The depth is set by the determinant path:
//   extension multiply, point setup, differences, split partial products,
//   product sum, determinant sign, then the rule logic.
// Reset
//   Synchronous, active low: clears all stage valid bits (in-flight requests
//   are dropped) and sets extend_epsilon to 1.
`default_nettype none

module segment_intersection_test_top (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire sit_pkg::sit_req_t           in_req,
  output logic                             out_strobe,
  output sit_pkg::sit_res_t                out_res,
  input  wire logic                        cfg_we,
  input  wire logic [sit_pkg::EPS_BITS-1:0] cfg_wdata
);

  localparam int NV = 6;  // valid bits for stages 1..6

  // ---------------------------------------------------------------- config
  logic [sit_pkg::EPS_BITS-1:0] eps_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= sit_pkg::EPS_BITS'(1);
    end else if (cfg_we) begin
      eps_r <= cfg_wdata;
    end
  end

  // The pipeline never stalls, so requests are always taken.
  assign busy = 1'b0;

  // ---------------------------------------------------------------- valids
  logic [NV-1:0] vld_r;
  logic          out_strobe_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r        <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      vld_r        <= {vld_r[NV-2:0], start & ~busy};
      out_strobe_r <= vld_r[NV-1];
    end
  end

  // ---------------------------------------------------------------- stage 1
  // Capture the request and form eps * dir.
  sit_pkg::sit_req_t                     req_r;
  logic signed [sit_pkg::EPROD_BITS-1:0] eprod_x_r;
  logic signed [sit_pkg::EPROD_BITS-1:0] eprod_y_r;

  always_ff @(posedge clk) begin
    req_r     <= in_req;
    eprod_x_r <= sit_pkg::EPROD_BITS'($signed({1'b0, eps_r})) *
                 sit_pkg::EPROD_BITS'(in_req.c_dir_x);
    eprod_y_r <= sit_pkg::EPROD_BITS'($signed({1'b0, eps_r})) *
                 sit_pkg::EPROD_BITS'(in_req.c_dir_y);
  end

  // ---------------------------------------------------------------- stage 2
  // Floor-shift the extension and lengthen CD at both ends.
  logic signed [sit_pkg::EXT_BITS-1:0] ext_x;
  logic signed [sit_pkg::EXT_BITS-1:0] ext_y;
  sit_pkg::sit_pt_t pa_r, pb_r, pc_r, pd_r;

  assign ext_x = $signed(eprod_x_r[sit_pkg::EPROD_BITS-1:sit_pkg::DIR_FRAC_BITS]);
  assign ext_y = $signed(eprod_y_r[sit_pkg::EPROD_BITS-1:sit_pkg::DIR_FRAC_BITS]);

  always_ff @(posedge clk) begin
    pa_r.x <= sit_pkg::PT_BITS'(req_r.a_start_x);
    pa_r.y <= sit_pkg::PT_BITS'(req_r.a_start_y);
    pb_r.x <= sit_pkg::PT_BITS'(req_r.a_end_x);
    pb_r.y <= sit_pkg::PT_BITS'(req_r.a_end_y);
    pc_r.x <= sit_pkg::PT_BITS'(req_r.c_start_x) - sit_pkg::PT_BITS'(ext_x);
    pc_r.y <= sit_pkg::PT_BITS'(req_r.c_start_y) - sit_pkg::PT_BITS'(ext_y);
    pd_r.x <= sit_pkg::PT_BITS'(req_r.c_end_x) + sit_pkg::PT_BITS'(ext_x);
    pd_r.y <= sit_pkg::PT_BITS'(req_r.c_end_y) + sit_pkg::PT_BITS'(ext_y);
  end

  // ---------------------------------------------------------------- stage 3
  // Each test is orient(p, q, r) with r checked against the box of p and q:
  // (A,B,C), (A,B,D), (C,D,A), (C,D,B).
  sit_pkg::sit_pt_t op_p [sit_pkg::N_ORIENT];
  sit_pkg::sit_pt_t op_q [sit_pkg::N_ORIENT];
  sit_pkg::sit_pt_t op_r [sit_pkg::N_ORIENT];

  logic signed [sit_pkg::DIFF_BITS-1:0] u1_r [sit_pkg::N_ORIENT];
  logic signed [sit_pkg::DIFF_BITS-1:0] v1_r [sit_pkg::N_ORIENT];
  logic signed [sit_pkg::DIFF_BITS-1:0] u2_r [sit_pkg::N_ORIENT];
  logic signed [sit_pkg::DIFF_BITS-1:0] v2_r [sit_pkg::N_ORIENT];
  logic [sit_pkg::N_ORIENT-1:0]         box3_r;

  always_comb begin
    op_p[0] = pa_r; op_q[0] = pb_r; op_r[0] = pc_r;
    op_p[1] = pa_r; op_q[1] = pb_r; op_r[1] = pd_r;
    op_p[2] = pc_r; op_q[2] = pd_r; op_r[2] = pa_r;
    op_p[3] = pc_r; op_q[3] = pd_r; op_r[3] = pb_r;
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < sit_pkg::N_ORIENT; k++) begin
      u1_r[k] <= sit_pkg::DIFF_BITS'(op_q[k].y) - sit_pkg::DIFF_BITS'(op_p[k].y);
      v1_r[k] <= sit_pkg::DIFF_BITS'(op_r[k].x) - sit_pkg::DIFF_BITS'(op_q[k].x);
      u2_r[k] <= sit_pkg::DIFF_BITS'(op_q[k].x) - sit_pkg::DIFF_BITS'(op_p[k].x);
      v2_r[k] <= sit_pkg::DIFF_BITS'(op_r[k].y) - sit_pkg::DIFF_BITS'(op_q[k].y);
      // bounds included; the box is given by p and q in either order
      box3_r[k] <= ((op_r[k].x <= op_p[k].x) || (op_r[k].x <= op_q[k].x)) &&
                   ((op_r[k].x >= op_p[k].x) || (op_r[k].x >= op_q[k].x)) &&
                   ((op_r[k].y <= op_p[k].y) || (op_r[k].y <= op_q[k].y)) &&
                   ((op_r[k].y >= op_p[k].y) || (op_r[k].y >= op_q[k].y));
    end
  end

  // ---------------------------------------------------------------- stage 4
  // Split the second operand of each product: unsigned low half and signed high half.
  logic signed [sit_pkg::PPL_BITS-1:0] pl1_r [sit_pkg::N_ORIENT];
  logic signed [sit_pkg::PPH_BITS-1:0] ph1_r [sit_pkg::N_ORIENT];
  logic signed [sit_pkg::PPL_BITS-1:0] pl2_r [sit_pkg::N_ORIENT];
  logic signed [sit_pkg::PPH_BITS-1:0] ph2_r [sit_pkg::N_ORIENT];
  logic [sit_pkg::N_ORIENT-1:0]        box4_r;

  always_ff @(posedge clk) begin
    for (int k = 0; k < sit_pkg::N_ORIENT; k++) begin
      pl1_r[k] <= sit_pkg::PPL_BITS'(u1_r[k]) *
                  sit_pkg::PPL_BITS'($signed({1'b0, v1_r[k][sit_pkg::LO_BITS-1:0]}));
      ph1_r[k] <= sit_pkg::PPH_BITS'(u1_r[k]) *
                  sit_pkg::PPH_BITS'($signed(
                    v1_r[k][sit_pkg::DIFF_BITS-1:sit_pkg::LO_BITS]));
      pl2_r[k] <= sit_pkg::PPL_BITS'(u2_r[k]) *
                  sit_pkg::PPL_BITS'($signed({1'b0, v2_r[k][sit_pkg::LO_BITS-1:0]}));
      ph2_r[k] <= sit_pkg::PPH_BITS'(u2_r[k]) *
                  sit_pkg::PPH_BITS'($signed(
                    v2_r[k][sit_pkg::DIFF_BITS-1:sit_pkg::LO_BITS]));
    end
    box4_r <= box3_r;
  end

  // ---------------------------------------------------------------- stage 5
  // Recombine the halves into the two full products.
  logic signed [sit_pkg::PROD_BITS-1:0] prod1_r [sit_pkg::N_ORIENT];
  logic signed [sit_pkg::PROD_BITS-1:0] prod2_r [sit_pkg::N_ORIENT];
  logic [sit_pkg::N_ORIENT-1:0]         box5_r;

  always_ff @(posedge clk) begin
    for (int k = 0; k < sit_pkg::N_ORIENT; k++) begin
      prod1_r[k] <= (sit_pkg::PROD_BITS'(ph1_r[k]) <<< sit_pkg::LO_BITS) +
                    sit_pkg::PROD_BITS'(pl1_r[k]);
      prod2_r[k] <= (sit_pkg::PROD_BITS'(ph2_r[k]) <<< sit_pkg::LO_BITS) +
                    sit_pkg::PROD_BITS'(pl2_r[k]);
    end
    box5_r <= box4_r;
  end

  // ---------------------------------------------------------------- stage 6
  // Determinant and its orientation code.
  logic signed [sit_pkg::DET_BITS-1:0] det [sit_pkg::N_ORIENT];
  logic [1:0]                          ori_r [sit_pkg::N_ORIENT];
  logic [sit_pkg::N_ORIENT-1:0]        box6_r;

  always_comb begin
    for (int k = 0; k < sit_pkg::N_ORIENT; k++) begin
      det[k] = sit_pkg::DET_BITS'(prod1_r[k]) - sit_pkg::DET_BITS'(prod2_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < sit_pkg::N_ORIENT; k++) begin
      if (det[k] == '0) begin
        ori_r[k] <= sit_pkg::ORI_COLL;
      end else if (det[k][sit_pkg::DET_BITS-1]) begin
        ori_r[k] <= sit_pkg::ORI_NEG;
      end else begin
        ori_r[k] <= sit_pkg::ORI_POS;
      end
    end
    box6_r <= box5_r;
  end

  // ---------------------------------------------------------------- stage 7
  // Straddle on both sides wins; otherwise any collinear point in its box.
  logic [1:0]        kind;
  sit_pkg::sit_res_t out_res_r;

  always_comb begin
    kind = sit_pkg::HIT_NONE;
    if ((ori_r[0] != ori_r[1]) && (ori_r[2] != ori_r[3])) begin
      kind = sit_pkg::HIT_PROPER;
    end else begin
      for (int k = 0; k < sit_pkg::N_ORIENT; k++) begin
        if ((ori_r[k] == sit_pkg::ORI_COLL) && box6_r[k]) begin
          kind = sit_pkg::HIT_COLL;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    out_res_r.intersects <= (kind != sit_pkg::HIT_NONE);
    out_res_r.hit_kind   <= kind;
  end

  assign out_strobe = out_strobe_r;
  assign out_res    = out_res_r;

endmodule

`default_nettype wire

// ----- bench/tb_segment_intersection_test_top.sv -----
// Testbench for segment_intersection_test_top: directed and shaped random segment pairs.
module tb_segment_intersection_test_top;
  import sit_pkg::*;

  localparam int     PIPE_DEPTH  = 7;
  localparam int     MAX_REPORTS = 20;
  localparam int     PHASES      = 6;
  localparam int     PHASE_REQS  = 200;
  localparam longint C_MIN       = -(longint'(1) << (COORD_BITS - 1));
  localparam longint C_MAX       = (longint'(1) << (COORD_BITS - 1)) - 1;

  // Keep a shadow of extend_epsilon, work out the hit of every accepted request
  // and hold it until the matching result leaves the pipeline.
  class hit_scoreboard;
    typedef struct {
      sit_req_t req;
      sit_res_t hit;
    } hit_entry_t;

    logic [EPS_BITS-1:0] epsilon;
    hit_entry_t          pending_hits[$];
    int unsigned         mismatches;
    int unsigned         requests;
    int unsigned         kind_seen[3];

    function new();
      epsilon    = 1;
      mismatches = 0;
      requests   = 0;
      foreach (kind_seen[i]) kind_seen[i] = 0;
    endfunction

    // Sign of the cross product (r - q) x (q - p), taken at 128 bits.
    function logic [1:0] orientation(longint px, longint py, longint qx, longint qy,
                                     longint rx, longint ry);
      logic signed [127:0] dy_pq, dx_qr, dx_pq, dy_qr, det;
      dy_pq = qy - py;
      dx_qr = rx - qx;
      dx_pq = qx - px;
      dy_qr = ry - qy;
      det   = dy_pq * dx_qr - dx_pq * dy_qr;
      if (det == 0) return ORI_COLL;
      return det[127] ? ORI_NEG : ORI_POS;
    endfunction

    // q inside the box spanned by p and r, bounds included.
    function bit in_box(longint px, longint py, longint qx, longint qy,
                        longint rx, longint ry);
      longint xmax, xmin, ymax, ymin;
      xmax = (px > rx) ? px : rx;
      xmin = (px < rx) ? px : rx;
      ymax = (py > ry) ? py : ry;
      ymin = (py < ry) ? py : ry;
      return qx <= xmax && qx >= xmin && qy <= ymax && qy >= ymin;
    endfunction

    function sit_res_t predict_hit(sit_req_t r);
      longint     ax, ay, bx, by, cx, cy, dx, dy, ext_x, ext_y;
      logic [1:0] o1, o2, o3, o4;
      sit_res_t   res;
      ax = longint'($signed(r.a_start_x));
      ay = longint'($signed(r.a_start_y));
      bx = longint'($signed(r.a_end_x));
      by = longint'($signed(r.a_end_y));
      cx = longint'($signed(r.c_start_x));
      cy = longint'($signed(r.c_start_y));
      dx = longint'($signed(r.c_end_x));
      dy = longint'($signed(r.c_end_y));
      // epsilon * dir, floor-shifted; CD grows at both ends with no wrap
      ext_x = (longint'({1'b0, epsilon}) * longint'($signed(r.c_dir_x))) >>> DIR_FRAC_BITS;
      ext_y = (longint'({1'b0, epsilon}) * longint'($signed(r.c_dir_y))) >>> DIR_FRAC_BITS;
      cx -= ext_x;
      cy -= ext_y;
      dx += ext_x;
      dy += ext_y;
      o1 = orientation(ax, ay, bx, by, cx, cy);
      o2 = orientation(ax, ay, bx, by, dx, dy);
      o3 = orientation(cx, cy, dx, dy, ax, ay);
      o4 = orientation(cx, cy, dx, dy, bx, by);
      res.hit_kind = HIT_NONE;
      if (o1 != o2 && o3 != o4) begin
        res.hit_kind = HIT_PROPER;
      end else if ((o1 == ORI_COLL && in_box(ax, ay, cx, cy, bx, by)) ||
                   (o2 == ORI_COLL && in_box(ax, ay, dx, dy, bx, by)) ||
                   (o3 == ORI_COLL && in_box(cx, cy, ax, ay, dx, dy)) ||
                   (o4 == ORI_COLL && in_box(cx, cy, bx, by, dx, dy))) begin
        res.hit_kind = HIT_COLL;
      end
      res.intersects = (res.hit_kind != HIT_NONE);
      return res;
    endfunction

    function void note_request(sit_req_t r);
      hit_entry_t e;
      e.req = r;
      e.hit = predict_hit(r);
      requests++;
      kind_seen[e.hit.hit_kind]++;
      pending_hits.push_back(e);
    endfunction

    function void check_hit(sit_res_t got);
      hit_entry_t want;
      if (pending_hits.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("%0t: result with no request pending: intersects=%0b hit_kind=%0d",
                   $time, got.intersects, got.hit_kind);
        mismatches++;
        return;
      end
      want = pending_hits.pop_front();
      if (got.intersects !== want.hit.intersects) begin
        if (mismatches < MAX_REPORTS)
          $display("%0t: intersects expected %0b actual %0b, eps=%0d req=%h", $time,
                   want.hit.intersects, got.intersects, epsilon, want.req);
        mismatches++;
      end
      if (got.hit_kind !== want.hit.hit_kind) begin
        if (mismatches < MAX_REPORTS)
          $display("%0t: hit_kind expected %0d actual %0d, eps=%0d req=%h", $time,
                   want.hit.hit_kind, got.hit_kind, epsilon, want.req);
        mismatches++;
      end
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  sit_req_t            in_req;
  logic                out_strobe;
  sit_res_t            out_res;
  logic                cfg_we;
  logic [EPS_BITS-1:0] cfg_wdata;

  hit_scoreboard sb;
  int unsigned   eps_settings;

  segment_intersection_test_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_req     (in_req),
    .out_strobe (out_strobe),
    .out_res    (out_res),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Check every strobed result against the oldest predicted hit. Treat an
  // unknown strobe as a result so that it shows up as a mismatch.
  always @(posedge clk) begin
    if (rst_n && out_strobe !== 1'b0) sb.check_hit(out_res);
  end

  // Pack eight coordinates and a direction into one request.
  function automatic sit_req_t make_req(longint ax, longint ay, longint bx, longint by,
                                        longint cx, longint cy, longint dx, longint dy,
                                        int dir_x, int dir_y);
    sit_req_t r;
    r.a_start_x = ax[COORD_BITS-1:0];
    r.a_start_y = ay[COORD_BITS-1:0];
    r.a_end_x   = bx[COORD_BITS-1:0];
    r.a_end_y   = by[COORD_BITS-1:0];
    r.c_start_x = cx[COORD_BITS-1:0];
    r.c_start_y = cy[COORD_BITS-1:0];
    r.c_end_x   = dx[COORD_BITS-1:0];
    r.c_end_y   = dy[COORD_BITS-1:0];
    r.c_dir_x   = dir_x[DIR_BITS-1:0];
    r.c_dir_y   = dir_y[DIR_BITS-1:0];
    return r;
  endfunction

  function automatic longint rand_within(longint reach);
    return longint'($urandom_range(0, 2 * reach)) - reach;
  endfunction

  function automatic longint edge_coord();
    case ($urandom_range(0, 5))
      0:       return C_MIN;
      1:       return C_MAX;
      2:       return 0;
      3:       return -1;
      4:       return 1;
      default: return longint'(int'($urandom));
    endcase
  endfunction

  function automatic int edge_dir();
    case ($urandom_range(0, 4))
      0:       return -32768;
      1:       return 32767;
      2:       return 0;
      3:       return -1;
      default: return int'($urandom);
    endcase
  endfunction

  // Draw one request. Plain random coordinates almost never land on the
  // collinear or extension-sensitive paths, so build most of them on purpose:
  // crossings in a small box, points on one lattice line, endpoints touching
  // the other segment, gaps close to the extension length, and range extremes.
  function automatic sit_req_t random_request();
    longint      v[8];
    longint      px, py, ux, uy, reach, half, len, g, m, k, tmp;
    int          dir_x, dir_y, d, sel;
    int unsigned eps;
    eps   = 32'(sb.epsilon);
    dir_x = 0;
    dir_y = 0;
    sel   = $urandom_range(0, 99);
    if (sel < 15) begin
      // noise over every bit of every field
      return {$urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom, $urandom, $urandom, $urandom};
    end
    if (sel < 45) begin
      reach = longint'(1) << $urandom_range(4, 24);
      foreach (v[i]) v[i] = rand_within(reach);
      dir_x = int'($urandom);
      dir_y = int'($urandom);
    end else if (sel < 65) begin
      // all four points on one line; keep the extension along that line
      px = rand_within(longint'(1) << 20);
      py = rand_within(longint'(1) << 20);
      d  = int'($urandom);
      case ($urandom_range(0, 3))
        0: begin
          ux = longint'($urandom_range(1, 1000)); uy = 0; dir_x = d;
        end
        1: begin
          ux = 0; uy = longint'($urandom_range(1, 1000)); dir_y = d;
        end
        2: begin
          ux = longint'($urandom_range(1, 1000)); uy = ux; dir_x = d; dir_y = d;
        end
        default: begin
          ux = rand_within(1000); uy = rand_within(1000);
        end
      endcase
      for (int i = 0; i < 4; i++) begin
        k        = rand_within(40);
        v[2*i]   = px + k * ux;
        v[2*i+1] = py + k * uy;
      end
    end else if (sel < 80) begin
      // C near or on segment AB, D off the line; sometimes swap the roles
      px   = rand_within(longint'(1) << 20);
      py   = rand_within(longint'(1) << 20);
      ux   = rand_within(1000);
      uy   = rand_within(1000);
      m    = longint'($urandom_range(1, 20));
      k    = longint'($urandom_range(0, 32'(m + 4))) - 2;
      v[0] = px;
      v[1] = py;
      v[2] = px + m * ux;
      v[3] = py + m * uy;
      v[4] = px + k * ux;
      v[5] = py + k * uy;
      v[6] = v[4] + rand_within(1000);
      v[7] = v[5] + rand_within(1000);
      if ($urandom_range(0, 1)) begin
        for (int i = 0; i < 4; i++) begin
          tmp = v[i]; v[i] = v[i+4]; v[i+4] = tmp;
        end
      end
    end else if (sel < 93) begin
      // vertical AB, horizontal CD ending a gap short of it; the extension
      // decides whether the gap closes
      px    = rand_within(longint'(1) << 20);
      half  = longint'($urandom_range(1, 1000));
      py    = rand_within(half + 2);
      len   = longint'($urandom_range(1, 5000));
      g     = longint'($urandom_range(0, eps + 2));
      dir_x = int'($urandom_range(30000, 32767));
      v[0]  = px;
      v[1]  = -half;
      v[2]  = px;
      v[3]  = half;
      v[4]  = px - g - len;
      v[5]  = py;
      v[6]  = px - g;
      v[7]  = py;
      if ($urandom_range(0, 1)) begin
        v[4]  = px + g + len;
        v[6]  = px + g;
        dir_x = ($urandom_range(0, 3) == 0) ? -32768 : -dir_x;
      end
    end else begin
      foreach (v[i]) v[i] = edge_coord();
      dir_x = edge_dir();
      dir_y = edge_dir();
    end
    // mirror about the diagonal now and then so both axes see each shape
    if ($urandom_range(0, 1)) begin
      for (int i = 0; i < 4; i++) begin
        tmp = v[2*i]; v[2*i] = v[2*i+1]; v[2*i+1] = tmp;
      end
      d = dir_x; dir_x = dir_y; dir_y = d;
    end
    return make_req(v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], dir_x, dir_y);
  endfunction

  // Hold start low for gap cycles, then present the request and wait for the
  // edge that takes it. Leave start high so back-to-back requests need no gap.
  task automatic send_request(input sit_req_t req, input int unsigned gap);
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_req <= req;
    start  <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_request(req);
  endtask

  // Drop start and wait until every predicted hit has come back, then let
  // the pipeline run empty.
  task automatic go_quiet();
    @(negedge clk);
    start <= 1'b0;
    while (sb.pending_hits.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 3) @(posedge clk);
  endtask

  // Write extend_epsilon with nothing in flight.
  task automatic write_epsilon(input logic [EPS_BITS-1:0] value);
    go_quiet();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    sb.epsilon = value;
    eps_settings++;
  endtask

  initial begin
    int unsigned         burst_left;
    int unsigned         gap;
    logic [EPS_BITS-1:0] eps_value;
    sb           = new();
    eps_settings = 1;
    burst_left   = 0;
    rst_n        = 1'b0;
    start        = 1'b0;
    in_req       = '0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed requests, run with epsilon at its reset value of 1: a
    // direction of -1 or -32768 then moves each end of CD by exactly one.
    // plain crossing, parallel, collinear overlap, collinear apart
    send_request(make_req(0, 0, 100, 100, 0, 100, 100, 0, 0, 0), $urandom_range(0, 15));
    send_request(make_req(0, 0, 100, 0, 0, 10, 100, 10, 0, 0), $urandom_range(0, 15));
    send_request(make_req(0, 0, 100, 0, 50, 0, 150, 0, 32767, 0), $urandom_range(0, 15));
    send_request(make_req(0, 0, 10, 0, 20, 0, 30, 0, 0, 0), $urandom_range(0, 15));
    // endpoint of CD on the inside of AB
    send_request(make_req(0, 0, 100, 0, 50, 0, 50, 50, 0, 0), $urandom_range(0, 15));
    // extension reaches AB by one step, then falls one step short
    send_request(make_req(0, -10, 0, 10, -1, 0, -50, 0, -32768, 0), $urandom_range(0, 15));
    send_request(make_req(0, -10, 0, 10, -2, 0, -50, 0, -32768, 0), $urandom_range(0, 15));
    // degenerate segments: point on a segment, same point, two apart points
    send_request(make_req(5, 5, 5, 5, 0, 0, 10, 10, 0, 0), $urandom_range(0, 15));
    send_request(make_req(7, 7, 7, 7, 7, 7, 7, 7, 0, 0), $urandom_range(0, 15));
    send_request(make_req(1, 2, 1, 2, 3, 4, 3, 4, 0, 0), $urandom_range(0, 15));
    // range extremes; at the minimum the extension leaves the coordinate range
    send_request(make_req(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX,
                          32767, 32767), $urandom_range(0, 15));
    send_request(make_req(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN,
                          -32768, -32768), $urandom_range(0, 15));
    send_request(make_req(C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MAX, C_MAX, C_MIN,
                          -32768, 32767), $urandom_range(0, 15));
    send_request(make_req(C_MAX, C_MIN, C_MAX, C_MAX, C_MIN, 0, C_MAX - 1, 0,
                          32767, -32768), $urandom_range(0, 15));
    // shared endpoint: the straddle rule wins over the collinear one
    send_request(make_req(0, 0, 10, 10, 10, 10, 20, 0, 0, 0), $urandom_range(0, 15));
    // collinear, only D inside AB; collinear, AB wholly inside CD
    send_request(make_req(0, 0, 100, 0, -50, 0, 50, 0, 0, 0), $urandom_range(0, 15));
    send_request(make_req(4, 0, 6, 0, 0, 0, 10, 0, 0, 0), $urandom_range(0, 15));
    // sloped collinear overlap, and a direction far from unit length
    send_request(make_req(0, 0, 30, 60, 10, 20, 50, 100, 0, 0), $urandom_range(0, 15));
    send_request(make_req(-8, 3, 9, -4, 2, 9, -3, -7, -32768, -32768),
                 $urandom_range(0, 15));

    // Random phases, each under its own epsilon; every write waits for the
    // pipeline to drain, so the sender also pauses with nothing in flight.
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       eps_value = 0;
        1:       eps_value = 16'hFFFF;
        2:       eps_value = 1;
        3:       eps_value = EPS_BITS'($urandom_range(2, 64));
        4:       eps_value = 4096;
        default: eps_value = EPS_BITS'($urandom);
      endcase
      write_epsilon(eps_value);
      for (int n = 0; n < PHASE_REQS; n++) begin
        // mix runs of back-to-back requests with randomly spaced ones
        if (burst_left == 0 && $urandom_range(0, 19) == 0) burst_left = $urandom_range(10, 40);
        if (burst_left > 0) begin
          gap = 0;
          burst_left--;
        end else begin
          gap = $urandom_range(0, 15);
        end
        send_request(random_request(), gap);
      end
    end

    go_quiet();
    $display("Ran %0d segment pairs under %0d epsilon settings (0, 1 and 65535 among them).",
             sb.requests, eps_settings);
    $display("Predicted %0d misses, %0d straddles, %0d collinear hits; %0d mismatches.",
             sb.kind_seen[HIT_NONE], sb.kind_seen[HIT_PROPER], sb.kind_seen[HIT_COLL],
             sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Stop a hung run: far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("Timeout with %0d results still pending.", sb.pending_hits.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule
